// File: rtl/ubdr_pkg.sv
// Package: shared types and constants for the fractional baud divider ratio block.
package ubdr_pkg;

    localparam int unsigned REF_CLOCK_RESET = 32'd20000000;
    localparam int unsigned DIVIDER_LIMIT_DEFAULT = 65536;
    localparam int unsigned SMALL_SHARE = 200;
    localparam int unsigned VAL_W = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TZ,
        ST_ODD,
        ST_GCD,
        ST_DIV,
        ST_CHECK,
        ST_QUOT,
        ST_HALVE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic strip_tz;
        logic make_odd;
        logic gcd_step;
        logic div_start;
        logic quot_start;
        logic halve;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic tz_done;
        logic odd_done;
        logic gcd_done;
        logic div_done;
        logic need_quot;
        logic fits;
    } status_t;

endpackage

// File: rtl/uart_baud_divider_ratio.sv
// Top level: fractional baud divider ratio (increment, modulator) computation.
//
// Input channel: req_baud with in_valid/in_stall. A zero baud is accepted
// and dropped without a result. Each nonzero item yields one result item on
// increment_minus_one / modulator_minus_one with out_valid/out_stall.
// One item is worked at a time; in_stall is high while an item is in work.
// Steps: the common-power-of-two strip, the odd-making shifts, the binary
// gcd, the two exact divisions by the gcd on a shared bit-serial divider,
// the optional rounded quotient on the same divider, and the halving.
// The user is to write the reference clock through cfg_we/cfg_data only
// while idle; the block itself does not enforce it. Reset sets it to
// 20000000 and returns the controller to idle with no result pending.
// While the receiver stalls, the result holds on the outputs and no new item
// is taken.
module uart_baud_divider_ratio #(
    parameter int unsigned DIVIDER_LIMIT = ubdr_pkg::DIVIDER_LIMIT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] req_baud,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] increment_minus_one,
    output logic [15:0] modulator_minus_one
);

    logic [31:0] ref_clock_reg;
    logic [23:0] baud_reg;
    logic        busy;
    logic        start;
    ubdr_pkg::cmd_t    cmd;
    ubdr_pkg::status_t st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_clock_reg <= ubdr_pkg::REF_CLOCK_RESET;
        end
        else if (cfg_we)
        begin
            ref_clock_reg <= cfg_data;
        end
    end

    // a zero baud is swallowed at the door
    assign in_stall = busy;
    assign start = in_valid && !busy && (req_baud != '0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            baud_reg <= req_baud;
        end
    end

    // out_valid exactly while the controller sits in its output state
    ubdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .out_free  (!out_stall),
        .st        (st),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    ubdr_dp #(.DIVIDER_LIMIT(DIVIDER_LIMIT)) u_dp (
        .clk       (clk),
        .ref_clock (ref_clock_reg),
        .baud      (baud_reg),
        .cmd       (cmd),
        .st        (st),
        .inc_m1    (increment_minus_one),
        .md_m1     (modulator_minus_one)
    );

endmodule

// File: rtl/ubdr_ctrl.sv
// Controller: sequences one item through the reduction steps.
module ubdr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              out_free,
    input  ubdr_pkg::status_t st,
    output ubdr_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              out_valid
);

    ubdr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ubdr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ubdr_pkg::ST_IDLE:  if (start) state_next = ubdr_pkg::ST_LOAD;
            ubdr_pkg::ST_LOAD:  state_next = ubdr_pkg::ST_TZ;
            ubdr_pkg::ST_TZ:    if (st.tz_done) state_next = ubdr_pkg::ST_ODD;
            ubdr_pkg::ST_ODD:   if (st.odd_done) state_next = ubdr_pkg::ST_GCD;
            ubdr_pkg::ST_GCD:   if (st.gcd_done) state_next = ubdr_pkg::ST_DIV;
            ubdr_pkg::ST_DIV:   if (st.div_done) state_next = ubdr_pkg::ST_CHECK;
            ubdr_pkg::ST_CHECK: state_next = st.need_quot ? ubdr_pkg::ST_QUOT
                                                           : ubdr_pkg::ST_HALVE;
            ubdr_pkg::ST_QUOT:  if (st.div_done) state_next = ubdr_pkg::ST_HALVE;
            ubdr_pkg::ST_HALVE: if (st.fits) state_next = ubdr_pkg::ST_OUT;
            ubdr_pkg::ST_OUT:   if (out_free) state_next = ubdr_pkg::ST_IDLE;
            default:            state_next = ubdr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ubdr_pkg::ST_IDLE:  busy = 1'b0;
            ubdr_pkg::ST_LOAD:  cmd.load = 1'b1;
            ubdr_pkg::ST_TZ:    cmd.strip_tz = 1'b1;
            ubdr_pkg::ST_ODD:   cmd.make_odd = 1'b1;
            ubdr_pkg::ST_GCD:   begin
                cmd.gcd_step = 1'b1;
                cmd.div_start = st.gcd_done;
            end
            ubdr_pkg::ST_DIV:   ;
            ubdr_pkg::ST_CHECK: cmd.quot_start = st.need_quot;
            ubdr_pkg::ST_QUOT:  ;
            ubdr_pkg::ST_HALVE: cmd.halve = 1'b1;
            ubdr_pkg::ST_OUT:   begin
                cmd.finish = out_free;
                out_valid = 1'b1;
            end
            default:            busy = 1'b0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ubdr_pkg::ST_IDLE && start) |=> state_reg == ubdr_pkg::ST_LOAD)
        else $error("start not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ubdr_pkg::ST_OUT && !out_free) |=> state_reg == ubdr_pkg::ST_OUT)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ubdr_pkg::ST_LOAD |=> state_reg == ubdr_pkg::ST_TZ)
        else $error("load sequence broken");

endmodule

// File: rtl/ubdr_dp.sv
// Datapath: reduction registers, binary gcd, shared bit-serial divider.
module ubdr_dp #(
    parameter int unsigned DIVIDER_LIMIT = ubdr_pkg::DIVIDER_LIMIT_DEFAULT
) (
    input  logic              clk,
    input  logic [31:0]       ref_clock,
    input  logic [23:0]       baud,
    input  ubdr_pkg::cmd_t    cmd,
    output ubdr_pkg::status_t st,
    output logic [15:0]       inc_m1,
    output logic [15:0]       md_m1
);

    localparam int W = ubdr_pkg::VAL_W;
    localparam logic [W-1:0] LIMIT = W'(DIVIDER_LIMIT);

    logic [W-1:0] md_reg, md_next, inc_reg, inc_next;
    logic [W-1:0] a_reg, a_next, b_reg, b_next;
    logic [W-1:0] g_reg, g_next;
    // divider: dividend q, remainder r, divisor d
    logic [W-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [1:0]   dsel_reg, dsel_next;  // 0 idle, 1 md, 2 inc, 3 quotient
    logic [W-1:0] rs, sh;
    logic [W:0]   diff;
    logic [W-1:0] dq;

    always_ff @(posedge clk)
    begin
        md_reg <= md_next; inc_reg <= inc_next;
        a_reg <= a_next; b_reg <= b_next; g_reg <= g_next;
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
        cnt_reg <= cnt_next; dsel_reg <= dsel_next;
    end

    always_comb
    begin
        rs = {r_reg[W-2:0], q_reg[W-1]};
        diff = {1'b0, rs} - {1'b0, d_reg};
        sh = diff[W] ? rs : diff[W-1:0];
        dq = {q_reg[W-2:0], ~diff[W]};
    end

    always_comb
    begin
        md_next = md_reg; inc_next = inc_reg;
        a_next = a_reg; b_next = b_reg; g_next = g_reg;
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; dsel_next = dsel_reg;
        if (cmd.load)
        begin
            md_next = {1'b0, ref_clock};
            inc_next = {5'd0, baud, 4'd0};
            dsel_next = 2'd0;
        end
        if (cmd.strip_tz && !md_reg[0] && !inc_reg[0])
        begin
            md_next = md_reg >> 1;
            inc_next = inc_reg >> 1;
        end
        if (cmd.strip_tz && st.tz_done)
        begin
            a_next = md_reg;
            b_next = inc_reg;
        end
        if (cmd.make_odd)
        begin
            if (a_reg != '0 && !a_reg[0]) a_next = a_reg >> 1;
            if (!b_reg[0]) b_next = b_reg >> 1;
        end
        if (cmd.gcd_step && !st.gcd_done)
        begin
            if (!a_reg[0]) a_next = a_reg >> 1;
            else if (!b_reg[0]) b_next = b_reg >> 1;
            else if (a_reg > b_reg) a_next = a_reg - b_reg;
            else b_next = b_reg - a_reg;
        end
        if (cmd.div_start)
        begin
            g_next = (a_reg == '0) ? b_reg : a_reg;
            d_next = (a_reg == '0) ? b_reg : a_reg;
            q_next = md_reg; r_next = '0; cnt_next = 6'(W); dsel_next = 2'd1;
        end
        else if (cmd.quot_start)
        begin
            d_next = inc_reg;
            q_next = md_reg + (inc_reg >> 1);
            r_next = '0; cnt_next = 6'(W); dsel_next = 2'd3;
        end
        else if (dsel_reg != 2'd0 && !cmd.load)
        begin
            if (cnt_reg != '0)
            begin
                q_next = dq; r_next = sh; cnt_next = cnt_reg - 6'd1;
            end
            else
            begin
                unique case (dsel_reg)
                    2'd1:
                    begin
                        md_next = q_reg;
                        d_next = g_reg; q_next = inc_reg; r_next = '0;
                        cnt_next = 6'(W); dsel_next = 2'd2;
                    end
                    2'd2:
                    begin
                        inc_next = q_reg; dsel_next = 2'd0;
                    end
                    2'd3:
                    begin
                        md_next = q_reg; inc_next = W'(1); dsel_next = 2'd0;
                    end
                    default: dsel_next = 2'd0;
                endcase
            end
        end
        if (cmd.halve && !st.fits)
        begin
            md_next = md_reg >> 1;
            inc_next = inc_reg >> 1;
        end
    end

    // md/200 avoided as a divide: inc < md/200 <=> 200*inc + 199 < md
    logic [W+8:0] inc200;
    assign inc200 = (W+9)'(inc_reg) * (W+9)'(ubdr_pkg::SMALL_SHARE)
                    + (W+9)'(ubdr_pkg::SMALL_SHARE - 1);

    always_comb
    begin
        st.tz_done = md_reg[0] || inc_reg[0];
        st.odd_done = (a_reg == '0 || a_reg[0]) && b_reg[0];
        st.gcd_done = (a_reg == '0) || (a_reg == b_reg);
        st.div_done = (dsel_reg == 2'd0);
        st.need_quot = (md_reg > LIMIT) && (inc200 < (W+9)'(md_reg));
        st.fits = (md_reg <= LIMIT) && (inc_reg <= LIMIT);
    end

    assign inc_m1 = (inc_reg == '0) ? 16'd0 : 16'(inc_reg - W'(1));
    assign md_m1 = (md_reg == '0) ? 16'd0 : 16'(md_reg - W'(1));

endmodule

// File: test/tb_top.sv
// Testbench for the fractional baud divider ratio block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LIMIT = ubdr_pkg::DIVIDER_LIMIT_DEFAULT;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [15:0] inc_m1;
        logic [15:0] mod_m1;
    } ratio_t;

    // Scoreboard: predicts the divider pair for each accepted baud and
    // checks results in order.
    class ratio_board;
        logic [31:0] ref_clk;
        ratio_t pending[$];
        int fails;

        function new();
            ref_clk = ubdr_pkg::REF_CLOCK_RESET;
            fails = 0;
        endfunction

        function int unsigned tz_count(logic [63:0] v);
            int unsigned n;
            n = 0;
            while (n < 63 && v[n] == 1'b0) n++;
            return n;
        endfunction

        function void note_baud(logic [23:0] baud);
            logic [63:0] md, inc, g, a, b;
            int unsigned tz;
            ratio_t r;
            if (baud == 0) return;
            md = {32'd0, ref_clk};
            inc = 64'd16 * baud;
            tz = tz_count(md | inc);
            md = md >> tz;
            inc = inc >> tz;
            if (md == 0) g = inc;
            else
            begin
                a = md >> tz_count(md);
                b = inc >> tz_count(inc);
                while (a != b)
                begin
                    if (a > b) begin a = a - b; a = a >> tz_count(a); end
                    else begin b = b - a; b = b >> tz_count(b); end
                end
                g = a;
            end
            md = md / g;
            inc = inc / g;
            if (md > LIMIT && inc < md / ubdr_pkg::SMALL_SHARE)
            begin
                md = (md + inc / 2) / inc;
                inc = 1;
            end
            while (md > LIMIT || inc > LIMIT)
            begin
                md = md / 2;
                inc = inc / 2;
            end
            if (md == 0) md = 1;
            if (inc == 0) inc = 1;
            r.inc_m1 = 16'(inc - 1);
            r.mod_m1 = 16'(md - 1);
            pending.push_back(r);
        endfunction

        function void check_ratio(logic [15:0] inc_m1, logic [15:0] mod_m1);
            ratio_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result inc=%0d mod=%0d", inc_m1, mod_m1);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (inc_m1 !== e.inc_m1)
            begin
                $error("increment_minus_one expected %0d actual %0d", e.inc_m1, inc_m1);
                fails++;
            end
            if (mod_m1 !== e.mod_m1)
            begin
                $error("modulator_minus_one expected %0d actual %0d", e.mod_m1, mod_m1);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [23:0] req_baud = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] increment_minus_one;
    logic [15:0] modulator_minus_one;

    ratio_board board = new();
    bit calm = 1'b0;         // long stretch with no idling on either side
    int unsigned quiet = 0;  // cycles since the last handshake on either channel

    always #5 clk = ~clk;

    uart_baud_divider_ratio u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .req_baud(req_baud),
        .out_valid(out_valid), .out_stall(out_stall),
        .increment_minus_one(increment_minus_one),
        .modulator_minus_one(modulator_minus_one)
    );

    // Sample both channels at the rising edge; the watchdog rides along.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) board.note_baud(req_baud);
            if (out_valid && !out_stall)
                board.check_ratio(increment_minus_one, modulator_minus_one);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("** uart_baud_divider_ratio: FAILED **");
                $finish;
            end
        end
    end

    // Receiver stall: about 22 percent, none during the calm stretch.
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 22);

    // Drive one baud item; idle gaps come first so the payload stays put
    // once valid is raised. Valid stays high after acceptance so items can
    // follow back to back; callers drop it when the stream pauses.
    task automatic send_baud(logic [23:0] b);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_baud <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Write the reference clock once all results are in and the block idles.
    task automatic set_ref_clock(logic [31:0] v);
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.ref_clk = v;
    endtask

    // Baud mix: common rates most often, some small, some zero, the rest full 24-bit range.
    function automatic logic [23:0] pick_baud();
        int unsigned k;
        int unsigned common_rates[8] = '{300, 1200, 9600, 19200, 38400,
                                         57600, 115200, 921600};
        k = $urandom_range(99);
        if (k < 40) return 24'(common_rates[$urandom_range(7)]);
        if (k < 65) return 24'($urandom_range(1, 4000));
        if (k < 70) return 24'd0;
        return 24'($urandom);
    endfunction

    initial
    begin
        logic [31:0] clocks[6] = '{32'd20000000, 32'd1, 32'hFFFFFFFF, 32'd0,
                                  32'd80000000, 32'd24000000};
        logic [23:0] directed[12] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd115200,
                                     24'd9600, 24'd1250000, 24'd3, 24'h800000,
                                     24'd0, 24'd7, 24'h555555, 24'hAAAAAA};
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Directed items at the reset clock value.
        foreach (directed[i]) send_baud(directed[i]);
        foreach (clocks[c])
        begin
            set_ref_clock(c == 0 ? $urandom : clocks[c]);
            foreach (directed[i]) if (i < 4) send_baud(directed[i]);
            for (int n = 0; n < 95; n++)
            begin
                calm = (c == 2 && n >= 20 && n < 70);
                send_baud(pick_baud());
            end
            calm = 1'b0;
        end
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.fails == 0)
            $display("** uart_baud_divider_ratio: PASSED **");
        else
            $display("** uart_baud_divider_ratio: FAILED **");
        $finish;
    end
endmodule

// File: files.f
rtl/ubdr_pkg.sv
rtl/ubdr_ctrl.sv
rtl/ubdr_dp.sv
rtl/uart_baud_divider_ratio.sv
test/tb_top.sv
